// File: hw/rtl/srdr_pkg.sv
package srdr_pkg;

  localparam int NUM_SETS          = 2048;
  localparam int NUM_WAYS          = 16;
  localparam int SIGNATURE_ENTRIES = 64;

  localparam int SET_W  = $clog2(NUM_SETS);
  localparam int WAY_W  = $clog2(NUM_WAYS);
  localparam int SIG_W  = $clog2(SIGNATURE_ENTRIES);
  localparam int CNT_W  = SET_W + 1;
  localparam int DECAY_W = 20;
  localparam int ADDR_W  = 64;
  localparam int STRIDE_ROW_W = 2 * ADDR_W + 2;
  localparam int LINE_ROW_W   = 4 * NUM_WAYS;

  localparam logic [1:0] CTR_MAX          = 2'd3;
  localparam logic [1:0] RRPV_MAX         = 2'd3;
  localparam logic [1:0] RRPV_LONG        = 2'd2;
  localparam logic [1:0] SIG_REUSE_THRESH = 2'd2;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 20'd100000;

  localparam logic CMD_QUERY  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef logic [NUM_WAYS-1:0][1:0] way_ctr_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DECAY
  } state_t;

  function automatic logic [1:0] sat_up(input logic [1:0] v);
    return (v == CTR_MAX) ? CTR_MAX : v + 2'd1;
  endfunction

  function automatic logic [1:0] sat_down(input logic [1:0] v);
    return (v == 2'd0) ? 2'd0 : v - 2'd1;
  endfunction

  function automatic way_ctr_t decay_row(input way_ctr_t d);
    way_ctr_t r;
    for (int i = 0; i < NUM_WAYS; i++) begin
      r[i] = sat_down(d[i]);
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/srdr_if.sv
interface srdr_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [10:0] set_index;
  logic [3:0]  way_index;
  logic [63:0] phys_address;
  logic [63:0] program_counter;
  logic        was_hit;

  modport source (output valid, command, set_index, way_index, phys_address,
                  program_counter, was_hit, input ready);
  modport sink (input valid, command, set_index, way_index, phys_address,
                program_counter, was_hit, output ready);
endinterface

interface srdr_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] victim_way;
  logic       bypassed;
  logic       streaming_seen;

  modport source (output valid, victim_way, bypassed, streaming_seen, input ready);
  modport sink (input valid, victim_way, bypassed, streaming_seen, output ready);
endinterface

// File: hw/rtl/signature_rrip_stream_dead_replacer_unit.sv
// Cache replacement engine: victim queries and replacement state updates.
// Channel req (sink) carries one item: command, set_index, way_index,
// phys_address, program_counter and was_hit. Channel rsp (source) returns
// one item per request: victim_way, bypassed and streaming_seen.
// cfg_we/cfg_data write the 20-bit decay period. The user must write it
// only while idle; the block itself does not enforce this. Each item goes
// through the synchronous read of the per-set stride memory, line memory
// and signature table, then a step to compute and write back. A new item
// can be taken in the cycle after the previous result is registered.
// When an update reaches the decay period, a sweep decrements every dead
// counter of the other sets through the line memory port (the update's own
// set is decayed by the update); req.ready stays low meanwhile. The
// result of that update is already visible. After reset the block clears
// all memories with req.ready low. The result is held in an output
// register; while it is not taken, req.ready stays low and nothing is lost.
module signature_rrip_stream_dead_replacer_unit (
  input  logic                          clk,
  input  logic                          rst,
  srdr_req_if.sink                      req,
  srdr_rsp_if.source                    rsp,
  input  logic                          cfg_we,
  input  logic [srdr_pkg::DECAY_W-1:0]  cfg_data
);
  import srdr_pkg::*;

  state_t state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [DECAY_W-1:0] decay_limit;
  logic [DECAY_W-1:0] since_decay, since_decay_next;

  logic               cur_cmd;
  logic [SET_W-1:0]   cur_set;
  logic [WAY_W-1:0]   cur_way;
  logic [ADDR_W-1:0]  cur_addr;
  logic [SIG_W-1:0]   cur_sig;
  logic               cur_hit;

  logic accept;
  logic [SET_W-1:0] rd_set, wr_set;
  logic [STRIDE_ROW_W-1:0] st_rdata, st_wdata;
  logic [LINE_ROW_W-1:0]   ln_rdata, ln_wdata;
  logic [1:0]              sg_rdata, sg_wdata;
  logic [SIG_W-1:0]        sg_raddr, sg_waddr;
  logic st_we, ln_we, sg_we;

  logic [ADDR_W-1:0] prev_addr, prev_stride, stride;
  logic [1:0]        conf, conf_new;
  logic              streaming, decay_now, bypass;
  logic [DECAY_W-1:0] since_inc;
  way_ctr_t dead_rd, rrpv_rd, dead_cur, dead_new, rrpv_new, rrpv_aged;
  logic [1:0] dw, dw_new, rw_new, sg_new;
  logic [WAY_W-1:0] victim;
  logic [SET_W-1:0] sweep_set;

  assign accept = req.valid && req.ready;
  assign {prev_addr, prev_stride, conf} = st_rdata;
  assign {dead_rd, rrpv_rd} = ln_rdata;

  srdr_ram #(.DEPTH(NUM_SETS), .WIDTH(STRIDE_ROW_W)) u_stride_ram (
    .clk(clk), .we(st_we), .waddr(wr_set), .wdata(st_wdata),
    .raddr(rd_set), .rdata(st_rdata)
  );

  srdr_ram #(.DEPTH(NUM_SETS), .WIDTH(LINE_ROW_W)) u_line_ram (
    .clk(clk), .we(ln_we), .waddr(wr_set), .wdata(ln_wdata),
    .raddr(rd_set), .rdata(ln_rdata)
  );

  srdr_ram #(.DEPTH(SIGNATURE_ENTRIES), .WIDTH(2)) u_sig_ram (
    .clk(clk), .we(sg_we), .waddr(sg_waddr), .wdata(sg_wdata),
    .raddr(sg_raddr), .rdata(sg_rdata)
  );

  srdr_way_pick u_way_pick (
    .dead(dead_rd), .rrpv(rrpv_rd), .victim(victim), .rrpv_aged(rrpv_aged)
  );

  always_comb begin
    stride    = cur_addr - prev_addr;
    conf_new  = (prev_stride != '0 && stride == prev_stride) ? sat_up(conf) : sat_down(conf);
    streaming = conf_new >= SIG_REUSE_THRESH;
    since_inc = since_decay + DECAY_W'(1);
    decay_now = since_inc >= decay_limit;
    dead_cur  = decay_now ? decay_row(dead_rd) : dead_rd;
    dw        = dead_cur[cur_way];
    bypass    = 1'b0;
    sg_new    = sg_rdata;
    if (cur_hit) begin
      sg_new = sat_up(sg_rdata);
      dw_new = 2'd0;
      rw_new = 2'd0;
    end else if (streaming || dw == CTR_MAX) begin
      bypass = 1'b1;
      dw_new = sat_up(dw);
      rw_new = RRPV_MAX;
      if (streaming) sg_new = sat_down(sg_rdata);
    end else if (sg_rdata >= SIG_REUSE_THRESH) begin
      dw_new = 2'd0;
      rw_new = 2'd0;
    end else begin
      dw_new = sat_up(dw);
      rw_new = RRPV_LONG;
    end
    dead_new = dead_cur;
    rrpv_new = rrpv_rd;
    dead_new[cur_way] = dw_new;
    rrpv_new[cur_way] = rw_new;
  end

  assign sweep_set = cnt[SET_W-1:0] - SET_W'(1);

  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    since_decay_next = since_decay;
    req.ready = 1'b0;
    rd_set    = req.set_index[SET_W-1:0];
    wr_set    = cur_set;
    sg_raddr  = req.program_counter[SIG_W+1:2] ^ req.program_counter[SIG_W+7:8];
    sg_waddr  = cur_sig;
    st_we = 1'b0;
    ln_we = 1'b0;
    sg_we = 1'b0;
    st_wdata = {cur_addr, stride, conf_new};
    ln_wdata = {dead_new, rrpv_new};
    sg_wdata = sg_new;
    unique case (state)
      ST_CLEAR: begin
        wr_set   = cnt[SET_W-1:0];
        sg_waddr = cnt[SIG_W-1:0];
        st_we = 1'b1;
        ln_we = 1'b1;
        sg_we = 1'b1;
        st_wdata = '0;
        ln_wdata = '0;
        sg_wdata = '0;
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req.ready = !rsp.valid || rsp.ready;
        if (accept) state_next = ST_READ;
      end
      ST_READ: begin
        if (cur_cmd == CMD_QUERY) begin
          ln_we    = 1'b1;
          ln_wdata = {dead_rd, rrpv_aged};
          state_next = ST_IDLE;
        end else begin
          st_we = 1'b1;
          ln_we = 1'b1;
          sg_we = 1'b1;
          if (decay_now) begin
            since_decay_next = '0;
            cnt_next   = '0;
            state_next = ST_DECAY;
          end else begin
            since_decay_next = since_inc;
            state_next = ST_IDLE;
          end
        end
      end
      ST_DECAY: begin
        rd_set   = cnt[SET_W-1:0];
        wr_set   = sweep_set;
        ln_wdata = {decay_row(dead_rd), rrpv_rd};
        ln_we    = (cnt != '0) && (sweep_set != cur_set);
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_SETS)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      cnt          <= '0;
      since_decay  <= '0;
      decay_limit  <= DECAY_RESET;
      rsp.valid    <= 1'b0;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      since_decay <= since_decay_next;
      if (cfg_we) decay_limit <= cfg_data;
      if (state == ST_READ) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_cmd  <= req.command;
      cur_set  <= req.set_index[SET_W-1:0];
      cur_way  <= req.way_index[WAY_W-1:0];
      cur_addr <= req.phys_address;
      cur_sig  <= sg_raddr;
      cur_hit  <= req.was_hit;
    end
    if (state == ST_READ) begin
      if (cur_cmd == CMD_QUERY) begin
        rsp.victim_way     <= victim;
        rsp.bypassed       <= 1'b0;
        rsp.streaming_seen <= 1'b0;
      end else begin
        rsp.victim_way     <= '0;
        rsp.bypassed       <= bypass;
        rsp.streaming_seen <= streaming;
      end
    end
  end

  a_accept_then_read: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_READ) else $error("accepted item not read");

  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> rsp.valid) else $error("result missing after read");

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECAY || state == ST_CLEAR) |-> !req.ready)
    else $error("item taken during sweep");

  a_query_no_bypass: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ && cur_cmd == CMD_QUERY) |=> !rsp.bypassed && !rsp.streaming_seen)
    else $error("query flagged as bypass");

endmodule

// File: hw/rtl/srdr_ram.sv
module srdr_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/srdr_way_pick.sv
module srdr_way_pick (
  input  srdr_pkg::way_ctr_t           dead,
  input  srdr_pkg::way_ctr_t           rrpv,
  output logic [srdr_pkg::WAY_W-1:0]   victim,
  output srdr_pkg::way_ctr_t           rrpv_aged
);
  import srdr_pkg::*;

  logic [1:0] top;
  logic [1:0] lift;
  logic       dead_found;
  logic [WAY_W-1:0] dead_way;
  logic [WAY_W-1:0] top_way;
  logic       top_found;

  always_comb begin
    dead_found = 1'b0;
    dead_way   = '0;
    for (int i = NUM_WAYS - 1; i >= 0; i--) begin
      if (dead[i] == CTR_MAX) begin
        dead_found = 1'b1;
        dead_way   = WAY_W'(i);
      end
    end
    top = 2'd0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (rrpv[i] > top) top = rrpv[i];
    end
    lift = RRPV_MAX - top;
    for (int i = 0; i < NUM_WAYS; i++) begin
      rrpv_aged[i] = dead_found ? rrpv[i] : rrpv[i] + lift;
    end
    top_found  = 1'b0;
    top_way    = '0;
    for (int i = NUM_WAYS - 1; i >= 0; i--) begin
      if (rrpv[i] == top) begin
        top_found = 1'b1;
        top_way   = WAY_W'(i);
      end
    end
    victim = dead_found ? dead_way : (top_found ? top_way : '0);
  end
endmodule

// File: tb/sv/signature_rrip_stream_dead_replacer_unit_tb.sv
`timescale 1ns / 100ps

module signature_rrip_stream_dead_replacer_unit_tb;
  import srdr_pkg::*;

  localparam int LIMIT = 3000000;

  typedef struct {
    logic [3:0] victim_way;
    logic       bypassed;
    logic       streaming_seen;
  } outcome_t;

  class replacer_scoreboard;
    logic [1:0]  sig_ctr [SIGNATURE_ENTRIES];
    logic [63:0] prior_addr [NUM_SETS];
    logic [63:0] last_stride [NUM_SETS];
    logic [1:0]  confidence [NUM_SETS];
    logic [1:0]  dead [NUM_SETS][NUM_WAYS];
    logic [1:0]  rrpv [NUM_SETS][NUM_WAYS];
    logic [19:0] since_decay;
    logic [19:0] period;
    outcome_t    awaited[$];
    int errors, queries, updates, bypasses, streams, decays, checked;

    function new();
      foreach (sig_ctr[i]) sig_ctr[i] = 0;
      foreach (prior_addr[i]) begin
        prior_addr[i] = 0;
        last_stride[i] = 0;
        confidence[i] = 0;
        for (int w = 0; w < NUM_WAYS; w++) begin
          dead[i][w] = 0;
          rrpv[i][w] = 0;
        end
      end
      since_decay = 0;
      period = DECAY_RESET;
    endfunction

    function logic [1:0] up(logic [1:0] v);
      return (v == CTR_MAX) ? CTR_MAX : v + 2'd1;
    endfunction

    function logic [1:0] down(logic [1:0] v);
      return (v == 2'd0) ? 2'd0 : v - 2'd1;
    endfunction

    function void note_input(logic cmd, logic [10:0] s, logic [3:0] w, logic [63:0] addr,
                             logic [63:0] pc, logic hit);
      outcome_t o;
      logic [63:0] stride;
      logic [1:0] top;
      logic [5:0] sig;
      logic strm;
      bit found;
      o.victim_way = 0;
      o.bypassed = 0;
      o.streaming_seen = 0;
      if (cmd == CMD_QUERY) begin
        queries++;
        found = 0;
        for (int i = 0; i < NUM_WAYS; i++)
          if (!found && dead[s][i] == CTR_MAX) begin
            o.victim_way = 4'(i);
            found = 1;
          end
        if (!found) begin
          top = 0;
          for (int i = 0; i < NUM_WAYS; i++) if (rrpv[s][i] > top) top = rrpv[s][i];
          for (int i = 0; i < NUM_WAYS; i++) rrpv[s][i] = rrpv[s][i] + (RRPV_MAX - top);
          for (int i = NUM_WAYS - 1; i >= 0; i--)
            if (rrpv[s][i] == RRPV_MAX) o.victim_way = 4'(i);
        end
      end else begin
        updates++;
        since_decay = since_decay + 20'd1;
        stride = addr - prior_addr[s];
        if (last_stride[s] != 0 && stride == last_stride[s]) confidence[s] = up(confidence[s]);
        else confidence[s] = down(confidence[s]);
        last_stride[s] = stride;
        prior_addr[s] = addr;
        strm = confidence[s] >= 2'd2;
        sig = pc[7:2] ^ pc[13:8];
        if (since_decay >= period) begin
          since_decay = 0;
          decays++;
          foreach (dead[a]) for (int b = 0; b < NUM_WAYS; b++) dead[a][b] = down(dead[a][b]);
        end
        if (hit) begin
          sig_ctr[sig] = up(sig_ctr[sig]);
          dead[s][w] = 0;
          rrpv[s][w] = 0;
        end else if (strm || dead[s][w] == CTR_MAX) begin
          o.bypassed = 1;
          dead[s][w] = up(dead[s][w]);
          if (strm) sig_ctr[sig] = down(sig_ctr[sig]);
          rrpv[s][w] = RRPV_MAX;
        end else if (sig_ctr[sig] >= SIG_REUSE_THRESH) begin
          dead[s][w] = 0;
          rrpv[s][w] = 0;
        end else begin
          dead[s][w] = up(dead[s][w]);
          rrpv[s][w] = RRPV_LONG;
        end
        o.streaming_seen = strm;
        bypasses += int'(o.bypassed);
        streams += int'(strm);
      end
      awaited.push_back(o);
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [3:0] vw, logic bp, logic ss);
      outcome_t o;
      if (awaited.size() == 0) begin
        report("result with nothing outstanding");
        return;
      end
      o = awaited.pop_front();
      checked++;
      if (vw !== o.victim_way)
        report($sformatf("victim_way %0d, expected %0d", vw, o.victim_way));
      if (bp !== o.bypassed)
        report($sformatf("bypassed %0b, expected %0b", bp, o.bypassed));
      if (ss !== o.streaming_seen)
        report($sformatf("streaming_seen %0b, expected %0b", ss, o.streaming_seen));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [DECAY_W-1:0] cfg_data = '0;
  int cycles = 0;
  bit calm = 0;
  replacer_scoreboard sb = new();

  srdr_req_if req ();
  srdr_rsp_if rsp ();

  signature_rrip_stream_dead_replacer_unit dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  logic [63:0] pc_pool [16];
  logic [10:0] hot_sets [8];

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int stall;
    rsp.ready = 0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) sb.check_result(rsp.victim_way, rsp.bypassed, rsp.streaming_seen);
      if (stall > 0) stall--;
      else if (!calm && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 17);
      rsp.ready <= (stall == 0);
    end
  end

  function logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task send(logic cmd, logic [10:0] s, logic [3:0] w, logic [63:0] addr, logic [63:0] pc,
            logic hit);
    int gap;
    req.valid <= 1;
    req.command <= cmd;
    req.set_index <= s;
    req.way_index <= w;
    req.phys_address <= addr;
    req.program_counter <= pc;
    req.was_hit <= hit;
    do @(posedge clk); while (!req.ready);
    sb.note_input(cmd, s, w, addr, pc, hit);
    if (!calm && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 17);
      req.valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task drain();
    req.valid <= 0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (NUM_SETS + 60) @(posedge clk);
  endtask

  task set_period(logic [DECAY_W-1:0] v);
    drain();
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.period = v;
  endtask

  task random_items(int total);
    int n, mode, len;
    logic [10:0] s;
    logic [3:0] w;
    logic [63:0] base, step, pc;
    n = 0;
    while (n < total) begin
      mode = $urandom_range(0, 99);
      s = ($urandom_range(0, 1)) ? hot_sets[$urandom_range(0, 7)] : 11'($urandom());
      w = 4'($urandom());
      pc = ($urandom_range(0, 3) != 0) ? pc_pool[$urandom_range(0, 15)] : rand64();
      if (mode < 15) begin
        len = $urandom_range(4, 7);
        base = rand64();
        step = ($urandom_range(0, 1)) ? 64'd64 : rand64();
        for (int i = 0; i < len; i++)
          send(CMD_UPDATE, s, 4'($urandom()), base + step * 64'(i), pc,
               $urandom_range(0, 4) == 0);
        n += len;
      end else if (mode < 27) begin
        len = $urandom_range(3, 4);
        for (int i = 0; i < len; i++) send(CMD_UPDATE, s, w, rand64(), rand64(), 0);
        send(CMD_QUERY, s, 4'($urandom()), rand64(), rand64(), 1'($urandom()));
        n += len + 1;
      end else if (mode < 60) begin
        send(CMD_QUERY, s, w, rand64(), rand64(), 1'($urandom()));
        n++;
      end else begin
        send(CMD_UPDATE, s, w, rand64(), pc, $urandom_range(0, 9) < 4);
        n++;
      end
    end
  endtask

  initial begin
    logic [63:0] pcr;
    foreach (pc_pool[i]) pc_pool[i] = rand64();
    foreach (hot_sets[i]) hot_sets[i] = 11'($urandom());
    pcr = 64'h4000;
    req.valid = 0;
    req.command = CMD_QUERY;
    req.set_index = 0;
    req.way_index = 0;
    req.phys_address = 0;
    req.program_counter = 0;
    req.was_hit = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(CMD_QUERY, 11'd0, 4'd0, 64'd0, 64'd0, 0);
    send(CMD_UPDATE, 11'd2047, 4'd15, '1, '1, 1);
    send(CMD_QUERY, 11'd2047, 4'd0, 64'd0, 64'd0, 0);
    send(CMD_UPDATE, 11'd5, 4'd3, 64'd100, pcr, 0);
    send(CMD_UPDATE, 11'd5, 4'd3, 64'd200, pcr, 0);
    send(CMD_UPDATE, 11'd5, 4'd3, 64'd333, pcr, 0);
    send(CMD_QUERY, 11'd5, 4'd0, 64'd0, 64'd0, 1);
    send(CMD_UPDATE, 11'd5, 4'd3, 64'd400, pcr, 0);
    send(CMD_UPDATE, 11'd6, 4'd1, 64'd0, pcr, 1);
    send(CMD_UPDATE, 11'd6, 4'd1, 64'd7, pcr, 1);
    send(CMD_UPDATE, 11'd6, 4'd2, 64'd9, pcr, 0);
    for (int i = 1; i <= 5; i++) send(CMD_UPDATE, 11'd9, i[3:0], 64'h1000 * 64'(i), pcr, 0);
    send(CMD_QUERY, 11'd9, 4'd0, '0, '0, 0);
    send(CMD_UPDATE, 11'd1, 4'd0, '0, '0, 0);
    send(CMD_QUERY, 11'd1, 4'd15, '1, '1, 1);
    random_items(200);

    set_period(20'd1);
    random_items(10);
    set_period(20'd0);
    random_items(5);
    set_period(20'hFFFFF);
    random_items(300);
    set_period(20'd37);
    random_items(300);
    set_period(20'd53);
    calm = 1;
    random_items(300);

    req.valid <= 0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Covered %0d queries and %0d updates (%0d bypasses, %0d streaming) over %0d decays",
             sb.queries, sb.updates, sb.bypasses, sb.streams, sb.decays);
    $display("%0d results checked in %0d cycles", sb.checked, cycles);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
